[src/imx_pkg.sv]
// ----------------------------------------------------------------------------
// imx_pkg: shared types and constants of the 3x3 matrix inverter
// Item layouts, internal widths and pipeline latencies of the lanes.
// ----------------------------------------------------------------------------
package imx_pkg;

   localparam int COEF_WIDTH  = 32;
   localparam int COF_WIDTH   = 2 * COEF_WIDTH + 1;
   localparam int DET_WIDTH   = 3 * COEF_WIDTH + 3;
   localparam int COF_LATENCY = 2;
   localparam int DET_LATENCY = 4;
   localparam int DIV_LATENCY = COEF_WIDTH + 3;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;
   typedef logic signed [COF_WIDTH-1:0]  cof_type;

   typedef struct packed {
      coef_type a_r0c0;
      coef_type a_r0c1;
      coef_type a_r0c2;
      coef_type a_r1c0;
      coef_type a_r1c1;
      coef_type a_r1c2;
      coef_type a_r2c0;
      coef_type a_r2c1;
      coef_type a_r2c2;
   } req_data_type;

   typedef struct packed {
      coef_type inv_r0c0;
      coef_type inv_r0c1;
      coef_type inv_r0c2;
      coef_type inv_r1c0;
      coef_type inv_r1c1;
      coef_type inv_r1c2;
      coef_type inv_r2c0;
      coef_type inv_r2c1;
      coef_type inv_r2c2;
      logic     singular;
   } rsp_data_type;

   typedef struct packed {
      logic [DET_WIDTH-1:0] mag;
      logic                 neg;
      logic                 zero;
   } det_info_type;

endpackage

[src/invert_matrix_3x3.sv]
// ----------------------------------------------------------------------------
// invert_matrix_3x3: fixed-point 3x3 matrix inverse by the adjugate method
// A new matrix is taken in every clock cycle; busy stays low. Each result
// appears on rsp_data with rsp_strobe high for one cycle, in order. The
// latency is set by the nine division lanes, which resolve one quotient
// bit per pipeline stage. The receiver cannot stall, so every result must
// be taken in the cycle it is shown. A zero determinant gives all-zero
// entries with the singular flag set; overflowing entries saturate.
// ----------------------------------------------------------------------------
module invert_matrix_3x3
   import imx_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_strobe,
   output rsp_data_type rsp_data
);

   localparam int VLD_LEN = COF_LATENCY + DET_LATENCY + DIV_LATENCY + 1;

   req_data_type in_ff;
   coef_type     m [3][3];
   cof_type      cof [3][3];
   coef_type     m0_ff [2][3];
   cof_type      cof_pipe_ff [DET_LATENCY][3][3];
   det_info_type det;
   coef_type     entry [3][3];
   logic         vld_ff  [VLD_LEN];
   logic         sing_ff [DIV_LATENCY];
   rsp_data_type rsp_in, rsp_ff;
   logic         rsp_valid_ff;

   assign busy = 1'b0;

   assign m[0][0] = in_ff.a_r0c0;
   assign m[0][1] = in_ff.a_r0c1;
   assign m[0][2] = in_ff.a_r0c2;
   assign m[1][0] = in_ff.a_r1c0;
   assign m[1][1] = in_ff.a_r1c1;
   assign m[1][2] = in_ff.a_r1c2;
   assign m[2][0] = in_ff.a_r2c0;
   assign m[2][1] = in_ff.a_r2c1;
   assign m[2][2] = in_ff.a_r2c2;

   for (genvar r = 0; r < 3; r++) begin : g_cof_row
      for (genvar c = 0; c < 3; c++) begin : g_cof_col
         imx_cof_lane u_cof (
            .clock (clock),
            .a     (m[(r+1)%3][(c+1)%3]),
            .b     (m[(r+2)%3][(c+2)%3]),
            .c     (m[(r+1)%3][(c+2)%3]),
            .d     (m[(r+2)%3][(c+1)%3]),
            .cof   (cof[r][c])
         );
      end
   end

   imx_det u_det (
      .clock (clock),
      .m0    (m0_ff[1]),
      .c0    (cof[0]),
      .det   (det)
   );

   for (genvar r = 0; r < 3; r++) begin : g_div_row
      for (genvar c = 0; c < 3; c++) begin : g_div_col
         imx_div_lane #(
            .FRAC_BITS (FRAC_BITS)
         ) u_div (
            .clock (clock),
            .cof   (cof_pipe_ff[DET_LATENCY-1][c][r]),
            .det   (det),
            .entry (entry[r][c])
         );
      end
   end

   always_comb begin
      rsp_in.inv_r0c0 = entry[0][0];
      rsp_in.inv_r0c1 = entry[0][1];
      rsp_in.inv_r0c2 = entry[0][2];
      rsp_in.inv_r1c0 = entry[1][0];
      rsp_in.inv_r1c1 = entry[1][1];
      rsp_in.inv_r1c2 = entry[1][2];
      rsp_in.inv_r2c0 = entry[2][0];
      rsp_in.inv_r2c1 = entry[2][1];
      rsp_in.inv_r2c2 = entry[2][2];
      rsp_in.singular = 1'b0;
      if (sing_ff[DIV_LATENCY-1]) begin
         rsp_in          = '0;
         rsp_in.singular = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      in_ff       <= req_data;
      m0_ff[0][0] <= m[0][0];
      m0_ff[0][1] <= m[0][1];
      m0_ff[0][2] <= m[0][2];
      m0_ff[1]    <= m0_ff[0];
      cof_pipe_ff[0] <= cof;
      for (int k = 1; k < DET_LATENCY; k++) begin
         cof_pipe_ff[k] <= cof_pipe_ff[k-1];
      end
      sing_ff[0] <= det.zero;
      for (int k = 1; k < DIV_LATENCY; k++) begin
         sing_ff[k] <= sing_ff[k-1];
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < VLD_LEN; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= start;
         for (int k = 1; k < VLD_LEN; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[VLD_LEN-1];
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(VLD_LEN+1) rsp_strobe)
      else $error("item result did not appear after the pipeline latency");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.singular) |-> (rsp_data.inv_r0c0 == '0 &&
         rsp_data.inv_r1c1 == '0 && rsp_data.inv_r2c2 == '0 &&
         rsp_data.inv_r0c2 == '0 && rsp_data.inv_r2c0 == '0))
      else $error("singular result carries nonzero entries");

   a_singular_align: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[COF_LATENCY+DET_LATENCY] && det.zero)
         |-> ##(DIV_LATENCY+1) (rsp_strobe && rsp_data.singular))
      else $error("zero determinant not flagged on its own item");

endmodule

[src/imx_cof_lane.sv]
// ----------------------------------------------------------------------------
// imx_cof_lane: one 2x2 cofactor lane
// Forms a*b - c*d exactly with a registered product stage and a registered
// difference stage.
// ----------------------------------------------------------------------------
module imx_cof_lane
   import imx_pkg::*;
(
   input  logic     clock,
   input  coef_type a,
   input  coef_type b,
   input  coef_type c,
   input  coef_type d,
   output cof_type  cof
);

   localparam int PROD_WIDTH = 2 * COEF_WIDTH;

   logic signed [PROD_WIDTH-1:0] p0_in, p0_ff;
   logic signed [PROD_WIDTH-1:0] p1_in, p1_ff;
   cof_type                      cof_in, cof_ff;

   assign p0_in  = PROD_WIDTH'(a) * PROD_WIDTH'(b);
   assign p1_in  = PROD_WIDTH'(c) * PROD_WIDTH'(d);
   assign cof_in = COF_WIDTH'(p0_ff) - COF_WIDTH'(p1_ff);

   always_ff @(posedge clock) begin
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      cof_ff <= cof_in;
   end

   assign cof = cof_ff;

endmodule

[src/imx_det.sv]
// ----------------------------------------------------------------------------
// imx_det: determinant merge
// Combines the first row with its cofactors into the exact determinant,
// splitting each wide product into two partial products.
// ----------------------------------------------------------------------------
module imx_det
   import imx_pkg::*;
(
   input  logic         clock,
   input  coef_type     m0 [3],
   input  cof_type      c0 [3],
   output det_info_type det
);

   localparam int PART_WIDTH = 2 * COEF_WIDTH + 1;

   logic signed [PART_WIDTH-1:0] lo_in [3];
   logic signed [PART_WIDTH-1:0] lo_ff [3];
   logic signed [PART_WIDTH-1:0] hi_in [3];
   logic signed [PART_WIDTH-1:0] hi_ff [3];
   logic signed [DET_WIDTH-1:0]  term_in [3];
   logic signed [DET_WIDTH-1:0]  term_ff [3];
   logic signed [DET_WIDTH-1:0]  sum_in, sum_ff;
   det_info_type                 det_in, det_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         lo_in[j] = PART_WIDTH'(m0[j])
                  * PART_WIDTH'($signed({1'b0, c0[j][COEF_WIDTH-1:0]}));
         hi_in[j] = PART_WIDTH'(m0[j])
                  * PART_WIDTH'($signed(c0[j][COF_WIDTH-1:COEF_WIDTH]));
         term_in[j] = (DET_WIDTH'(hi_ff[j]) <<< COEF_WIDTH) + DET_WIDTH'(lo_ff[j]);
      end
   end

   assign sum_in = term_ff[0] + term_ff[1] + term_ff[2];

   always_comb begin
      det_in.neg  = sum_ff[DET_WIDTH-1];
      det_in.zero = (sum_ff == '0);
      det_in.mag  = sum_ff[DET_WIDTH-1] ? DET_WIDTH'(-sum_ff) : DET_WIDTH'(sum_ff);
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      det_ff  <= det_in;
   end

   assign det = det_ff;

endmodule

[src/imx_div_lane.sv]
// ----------------------------------------------------------------------------
// imx_div_lane: one inverse entry lane
// Pipelined restoring division of the scaled cofactor by the determinant,
// one quotient bit per stage, with sign restore and saturation.
// ----------------------------------------------------------------------------
module imx_div_lane
   import imx_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic         clock,
   input  cof_type      cof,
   input  det_info_type det,
   output coef_type     entry
);

   localparam int NUM_WIDTH = COF_WIDTH + 2 * FRAC_BITS;
   localparam int LIM_WIDTH = DET_WIDTH + COEF_WIDTH;
   localparam int REM_WIDTH = (NUM_WIDTH > LIM_WIDTH) ? NUM_WIDTH : LIM_WIDTH;

   logic [COF_WIDTH-1:0]  cof_mag;
   logic [REM_WIDTH-1:0]  num_ff;
   logic [DET_WIDTH-1:0]  den0_ff;
   logic                  neg0_ff;

   logic [REM_WIDTH-1:0]  rem_in [COEF_WIDTH+1];
   logic [REM_WIDTH-1:0]  rem_ff [COEF_WIDTH+1];
   logic [DET_WIDTH-1:0]  den_ff [COEF_WIDTH+1];
   logic [COEF_WIDTH-1:0] q_in   [COEF_WIDTH+1];
   logic [COEF_WIDTH-1:0] q_ff   [COEF_WIDTH+1];
   logic                  neg_ff [COEF_WIDTH+1];
   logic                  ovf_ff [COEF_WIDTH+1];

   logic [COEF_WIDTH-1:0] q_last;
   coef_type              entry_in, entry_ff;

   assign cof_mag = cof[COF_WIDTH-1] ? COF_WIDTH'(-cof) : COF_WIDTH'(cof);

   always_comb begin
      rem_in[0] = num_ff;
      q_in[0]   = '0;
      for (int s = 0; s < COEF_WIDTH; s++) begin
         logic [REM_WIDTH-1:0] shifted;
         shifted = REM_WIDTH'(den_ff[s]) << (COEF_WIDTH - 1 - s);
         q_in[s+1] = q_ff[s];
         if (rem_ff[s] >= shifted) begin
            rem_in[s+1] = rem_ff[s] - shifted;
            q_in[s+1][COEF_WIDTH-1-s] = 1'b1;
         end else begin
            rem_in[s+1] = rem_ff[s];
         end
      end
   end

   assign q_last = q_ff[COEF_WIDTH];

   always_comb begin
      if (!neg_ff[COEF_WIDTH]) begin
         if (ovf_ff[COEF_WIDTH] || q_last[COEF_WIDTH-1]) begin
            entry_in = {1'b0, {(COEF_WIDTH-1){1'b1}}};
         end else begin
            entry_in = $signed(q_last);
         end
      end else begin
         if (ovf_ff[COEF_WIDTH] || (q_last[COEF_WIDTH-1] && |q_last[COEF_WIDTH-2:0])) begin
            entry_in = {1'b1, {(COEF_WIDTH-1){1'b0}}};
         end else begin
            entry_in = $signed(-q_last);
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= REM_WIDTH'(cof_mag) << (2 * FRAC_BITS);
      den0_ff   <= det.mag;
      neg0_ff   <= cof[COF_WIDTH-1] ^ det.neg;
      rem_ff[0] <= rem_in[0];
      q_ff[0]   <= q_in[0];
      den_ff[0] <= den0_ff;
      neg_ff[0] <= neg0_ff;
      ovf_ff[0] <= (num_ff >= (REM_WIDTH'(den0_ff) << COEF_WIDTH));
      for (int s = 0; s < COEF_WIDTH; s++) begin
         rem_ff[s+1] <= rem_in[s+1];
         q_ff[s+1]   <= q_in[s+1];
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         ovf_ff[s+1] <= ovf_ff[s];
      end
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
